// ----- hdl/assert_macros.svh -----
// Assertion helper macros shared by the factoradic converter RTL.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define IFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define IFD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ifd_pkg.sv -----
// Shared types and constants for the integer-to-factoradic converter.
// No dependencies.
package ifd_pkg;

	localparam int VALUE_W = 32;
	localparam int DIGIT_W = 4;
	localparam int TLEN_W  = 5;
	localparam int RADIX_W = 5;
	localparam int CNT_W   = $clog2(VALUE_W);

	// digit count limit: MAX_DIGITS capped by the width of the position field
	localparam int MAX_DIGITS = 16;
	localparam int POS_LIMIT  = (MAX_DIGITS < (1 << DIGIT_W)) ? MAX_DIGITS : (1 << DIGIT_W);

	localparam logic [TLEN_W-1:0] TLEN_RESET = TLEN_W'(13);
	localparam logic [TLEN_W-1:0] TLEN_LIMIT = TLEN_W'(POS_LIMIT);

	typedef struct packed {
		logic load;   // take a new dividend
		logic start;  // begin a serial divide of the held dividend
	} ifd_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;   // one-cycle pulse, quotient and remainder valid
	} ifd_div_sts_t;

endpackage

// ----- hdl/ifd_divider.sv -----
// Bit-serial restoring divider: 32-bit dividend by a 5-bit radix, one bit per cycle
// when neither load nor start is set. Depends on ifd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ifd_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ifd_pkg::ifd_div_ctl_t         ctl,
	input  logic [ifd_pkg::VALUE_W-1:0]   value,
	input  logic [ifd_pkg::RADIX_W-1:0]   divisor,
	output ifd_pkg::ifd_div_sts_t         sts,
	output logic [ifd_pkg::VALUE_W-1:0]   quot,
	output logic [ifd_pkg::DIGIT_W-1:0]   rem
);
	import ifd_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

	logic [VALUE_W-1:0] q_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [RADIX_W-1:0] trial;
	logic               fits;

	// remainder stays below the divisor, so its low bits plus the next dividend bit fit
	assign trial = {rem_q[RADIX_W-2:0], q_q[VALUE_W-1]};
	assign fits  = (trial >= div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q    <= '0;
			rem_q  <= '0;
			div_q  <= RADIX_W'(2);
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (ctl.load) begin
				q_q <= value;
			end else if (ctl.start) begin
				rem_q  <= '0;
				div_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// shift one quotient bit in as the dividend bit shifts out
				q_q   <= {q_q[VALUE_W-2:0], fits};
				rem_q <= fits ? (trial - div_q) : trial;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = q_q;
	assign rem      = rem_q[DIGIT_W-1:0];

	`IFD_ASSERT(a_done_follows_busy, done_q |-> $past(busy_q), "divider done without a busy pass")
	`IFD_ASSERT(a_rem_below_div, done_q |-> (rem_q < div_q), "remainder not below divisor")

endmodule

// ----- hdl/integer_to_factoradic_core.sv -----
// Integer-to-factoradic converter: sequencer, output register and config register.
// Depends on ifd_pkg, ifd_divider and assert_macros.svh.
// Digit 0 is registered and valid in the cycle after a word is accepted; each later
// digit needs a serial divide while the running quotient is nonzero, and follows
// in the cycle after the take once it is zero. A new word is taken only in ST_IDLE,
// after the last digit. Reset: control cleared, table_length 13.
`include "assert_macros.svh"

module integer_to_factoradic_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: table_length
	input  logic                          cfg_wen,
	input  logic [ifd_pkg::TLEN_W-1:0]    cfg_wdata,
	// input words
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ifd_pkg::VALUE_W-1:0]   value,
	// output words, one per digit
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ifd_pkg::DIGIT_W-1:0]   digit,
	output logic [ifd_pkg::DIGIT_W-1:0]   position,
	output logic                          last
);
	import ifd_pkg::*;

	// Sequencer states:
	//   ST_IDLE  wait for a word
	//   ST_EMIT  output register holds a digit until the sink takes it
	//   ST_DIV   serial divider is producing the next digit
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EMIT = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	state_t               state_q;
	logic [TLEN_W-1:0]    tlen_q;
	logic [DIGIT_W-1:0]   pos_q;
	logic [DIGIT_W-1:0]   last_pos_q;
	logic [DIGIT_W-1:0]   digit_q;
	logic                 last_q;
	logic                 out_valid_q;

	ifd_div_ctl_t         div_ctl;
	ifd_div_sts_t         div_sts;
	logic [VALUE_W-1:0]   div_quot;
	logic [DIGIT_W-1:0]   div_rem;
	logic [RADIX_W-1:0]   divisor;

	logic [DIGIT_W-1:0]   last_pos;
	logic [DIGIT_W-1:0]   nxt_pos;
	logic                 nxt_last;
	logic                 quot_zero;
	logic                 in_take;
	logic                 out_take;

	// Highest position to emit: table length clamped to 1..POS_LIMIT, minus one.
	always_comb begin
		priority if (tlen_q == '0) begin
			last_pos = '0;
		end else if (tlen_q > TLEN_LIMIT) begin
			last_pos = DIGIT_W'(TLEN_LIMIT - TLEN_W'(1));
		end else begin
			last_pos = DIGIT_W'(tlen_q - TLEN_W'(1));
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;

	assign nxt_pos   = pos_q + DIGIT_W'(1);
	assign nxt_last  = (nxt_pos == last_pos_q);
	// once the quotient is exhausted every higher digit is zero: skip the divide
	assign quot_zero = (div_quot == '0);
	// digit at position k is the remainder by k+1, so the next radix is pos+2
	assign divisor   = RADIX_W'(pos_q) + RADIX_W'(2);

	assign div_ctl.load  = in_take;
	assign div_ctl.start = (state_q == ST_EMIT) && out_take && !last_q && !quot_zero;

	ifd_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.value   (value),
		.divisor (divisor),
		.sts     (div_sts),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tlen_q      <= TLEN_RESET;
			pos_q       <= '0;
			last_pos_q  <= '0;
			digit_q     <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				tlen_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					// digit 0 is always zero: present it at once
					if (in_take) begin
						pos_q       <= '0;
						last_pos_q  <= last_pos;
						digit_q     <= '0;
						last_q      <= (last_pos == '0);
						out_valid_q <= 1'b1;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_take) begin
						priority if (last_q) begin
							// drop any leftover quotient
							out_valid_q <= 1'b0;
							state_q     <= ST_IDLE;
						end else if (quot_zero) begin
							pos_q   <= nxt_pos;
							digit_q <= '0;
							last_q  <= nxt_last;
						end else begin
							out_valid_q <= 1'b0;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					// hold until the serial divide finishes, then advance one position
					if (div_sts.done) begin
						pos_q       <= nxt_pos;
						digit_q     <= div_rem;
						last_q      <= nxt_last;
						out_valid_q <= 1'b1;
						state_q     <= ST_EMIT;
					end
				end
				default: begin
					out_valid_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign digit     = digit_q;
	assign position  = pos_q;
	assign last      = last_q;

	`IFD_ASSERT(a_digit_le_pos, out_valid_q |-> (digit_q <= pos_q), "digit exceeds its position")
	`IFD_ASSERT(a_busy_in_div, div_sts.busy |-> (state_q == ST_DIV), "divider busy outside divide state")
	`IFD_ASSERT(a_last_ends_item, (out_take && last_q) |=> !out_valid_q, "output after final digit")

endmodule
